// ===== src/spts_pkg.sv =====
package spts_pkg;

   // Default configuration
   localparam int LEVELS_DEF      = 10;
   localparam int POOL_DEPTH_DEF  = 64;
   localparam int HANDLE_BITS_DEF = 16;

   // Field widths of the request and response
   localparam int FUNC_W   = 2;
   localparam int HANDLE_W = 16;
   localparam int PRIO_W   = 4;
   localparam int STATUS_W = 3;
   localparam int LEVEL_W  = 4;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REPORT   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_PRIO     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL         = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE_RUNNING = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [HANDLE_W-1:0] task_handle;
      logic [PRIO_W-1:0]   priority_req;
      logic                finished;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] run_handle;
      logic [LEVEL_W-1:0]  run_level;
      logic                run_valid;
   } rsp_type;

   // Per-level queue update command
   typedef struct packed {
      logic append;
      logic pop;
   } cell_op_type;

endpackage

// ===== src/spts_ram.sv =====
module spts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/spts_level_cell.sv =====
module spts_level_cell import spts_pkg::*; #(
   parameter int PW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_op_type   op,
   input  logic [PW-1:0] entry,
   input  logic [PW-1:0] next_head,
   input  logic          higher_found,
   output logic          found,
   output logic          select,
   output logic          nonempty,
   output logic [PW-1:0] head,
   output logic [PW-1:0] tail
);

   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic          nonempty_ff, nonempty_in;

   // Queue pointer update: append at tail, pop at head
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      nonempty_in = nonempty_ff;
      if (op.append) begin
         tail_in = entry;
         if (!nonempty_ff) begin
            head_in     = entry;
            nonempty_in = 1'b1;
         end
      end else if (op.pop) begin
         if (head_ff == tail_ff) begin
            nonempty_in = 1'b0;
         end else begin
            head_in = next_head;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         nonempty_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         nonempty_ff <= nonempty_in;
      end
   end

   // Priority ripple: this level wins if it is queued and nothing above is queued
   assign found    = higher_found | nonempty_ff;
   assign select   = nonempty_ff & ~higher_found;
   assign nonempty = nonempty_ff;
   assign head     = head_ff;
   assign tail     = tail_ff;

endmodule

// ===== src/strict_priority_task_scheduler.sv =====
// A request accepted in S_IDLE is registered as the state moves to S_EXEC; there the
// registered reads of the link and handle memories return, any link write is made
// and the response is registered. No new request is taken until the block is idle.
// The receiver cannot stall; each response is shown for one cycle only.
// Reset (synchronous): queues empty, nothing running; then a pass over every pool
// entry chains the free list, with busy high until it completes.
module strict_priority_task_scheduler import spts_pkg::*; #(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int PW      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW      = $clog2(POOL_DEPTH + 1);
   localparam int LW      = $clog2(LEVELS);
   localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   localparam logic [PW-1:0] LAST_ENTRY = PW'(POOL_DEPTH - 1);

   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] clr_ff, clr_in;
   req_type       req_ff, req_in;
   logic [PW-1:0] free_head_ff, free_head_in;
   logic [CW-1:0] free_cnt_ff, free_cnt_in;
   logic [PW-1:0] run_entry_ff, run_entry_in;
   logic [LW-1:0] run_level_ff, run_level_in;
   logic          run_valid_ff, run_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          strobe_ff, strobe_in;

   logic          accept;

   // Level cell chain
   logic [LEVELS:0]   found_chain;
   logic [LEVELS-1:0] cell_sel;
   logic [LEVELS-1:0] cell_nonempty;
   logic [PW-1:0]     cell_head [LEVELS];
   logic [PW-1:0]     cell_tail [LEVELS];
   cell_op_type       cell_op   [LEVELS];

   logic [LW-1:0] sel_idx;
   logic [PW-1:0] sel_head;

   // Memory ports
   logic               link_we;
   logic [PW-1:0]      link_wa, link_ra;
   logic [PW-1:0]      link_wd, link_rd;
   logic               hnd_we;
   logic [PW-1:0]      hnd_ra;
   logic [STORE_W-1:0] hnd_rd;

   // Execute-cycle decisions
   logic          app_en, pop_en;
   logic [LW-1:0] app_lvl;
   logic [PW-1:0] app_entry;
   logic          ex_link_we;
   logic [PW-1:0] ex_link_wa, ex_link_wd;
   logic [PRIO_W-1:0] prio_m1;
   logic              prio_ok;
   logic [HANDLE_W-1:0] hnd_ext;
   logic [LEVEL_W-1:0]  lvl_ext;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start & ~busy;

   assign found_chain[LEVELS] = 1'b0;

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      assign cell_op[i].append = app_en && (app_lvl == LW'(i));
      assign cell_op[i].pop    = pop_en && cell_sel[i];

      spts_level_cell #(
         .PW (PW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .op           (cell_op[i]),
         .entry        (app_entry),
         .next_head    (link_rd),
         .higher_found (found_chain[i+1]),
         .found        (found_chain[i]),
         .select       (cell_sel[i]),
         .nonempty     (cell_nonempty[i]),
         .head         (cell_head[i]),
         .tail         (cell_tail[i])
      );
   end

   // Encode the winning level and its head entry
   always_comb begin
      sel_idx  = '0;
      sel_head = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (cell_sel[i]) begin
            sel_idx  = sel_idx | LW'(i);
            sel_head = sel_head | cell_head[i];
         end
      end
   end

   // Read addresses are issued in the accept cycle
   assign link_ra = (req_item.func == FUNC_PUSH) ? free_head_ff : sel_head;
   assign hnd_ra  = run_valid_ff ? run_entry_ff : sel_head;

   spts_ram #(
      .WIDTH (PW),
      .DEPTH (POOL_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   spts_ram #(
      .WIDTH (STORE_W),
      .DEPTH (POOL_DEPTH)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (hnd_we),
      .wr_addr (free_head_ff),
      .wr_data (req_ff.task_handle[STORE_W-1:0]),
      .rd_addr (hnd_ra),
      .rd_data (hnd_rd)
   );

   assign prio_m1 = req_ff.priority_req - PRIO_W'(1);
   assign prio_ok = (req_ff.priority_req != '0) &&
                    ({1'b0, req_ff.priority_req} <= (PRIO_W + 1)'(LEVELS));

   always_comb begin
      hnd_ext              = '0;
      hnd_ext[STORE_W-1:0] = hnd_rd;
      lvl_ext              = '0;
      lvl_ext[LW-1:0]      = run_valid_ff ? run_level_ff : sel_idx;
   end

   // Execute: at most one link write, pointer and running-task updates, response
   always_comb begin
      app_en       = 1'b0;
      pop_en       = 1'b0;
      app_lvl      = prio_m1[LW-1:0];
      app_entry    = free_head_ff;
      ex_link_we   = 1'b0;
      ex_link_wa   = '0;
      ex_link_wd   = '0;
      hnd_we       = 1'b0;
      free_head_in = free_head_ff;
      free_cnt_in  = free_cnt_ff;
      run_entry_in = run_entry_ff;
      run_level_in = run_level_ff;
      run_valid_in = run_valid_ff;
      rsp_in       = '0;
      rsp_in.status = ST_OK;
      if (state_ff == S_EXEC) begin
         case (req_ff.func)
            FUNC_PUSH: begin
               if (!prio_ok) begin
                  rsp_in.status = ST_BAD_PRIO;
               end else if (free_cnt_ff == '0) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  app_en       = 1'b1;
                  hnd_we       = 1'b1;
                  free_head_in = link_rd;
                  free_cnt_in  = free_cnt_ff - CW'(1);
                  if (cell_nonempty[app_lvl]) begin
                     ex_link_we = 1'b1;
                     ex_link_wa = cell_tail[app_lvl];
                     ex_link_wd = free_head_ff;
                  end
               end
            end
            FUNC_DISPATCH: begin
               if (run_valid_ff) begin
                  rsp_in.run_handle = hnd_ext;
                  rsp_in.run_level  = lvl_ext;
                  rsp_in.run_valid  = 1'b1;
               end else if (!found_chain[0]) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  pop_en            = 1'b1;
                  run_entry_in      = sel_head;
                  run_level_in      = sel_idx;
                  run_valid_in      = 1'b1;
                  rsp_in.run_handle = hnd_ext;
                  rsp_in.run_level  = lvl_ext;
                  rsp_in.run_valid  = 1'b1;
               end
            end
            FUNC_REPORT: begin
               if (!run_valid_ff) begin
                  rsp_in.status = ST_NONE_RUNNING;
               end else begin
                  run_valid_in = 1'b0;
                  if (req_ff.finished) begin
                     // return entry to the free list
                     ex_link_we   = 1'b1;
                     ex_link_wa   = run_entry_ff;
                     ex_link_wd   = free_head_ff;
                     free_head_in = run_entry_ff;
                     free_cnt_in  = free_cnt_ff + CW'(1);
                  end else begin
                     // requeue at the tail of its own level
                     app_en    = 1'b1;
                     app_lvl   = run_level_ff;
                     app_entry = run_entry_ff;
                     if (cell_nonempty[run_level_ff]) begin
                        ex_link_we = 1'b1;
                        ex_link_wa = cell_tail[run_level_ff];
                        ex_link_wd = run_entry_ff;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Link memory write: free-list chaining pass after reset, else execute
   always_comb begin
      if (state_ff == S_CLEAR) begin
         link_we = 1'b1;
         link_wa = clr_ff;
         link_wd = (clr_ff == LAST_ENTRY) ? '0 : clr_ff + PW'(1);
      end else begin
         link_we = ex_link_we;
         link_wa = ex_link_wa;
         link_wd = ex_link_wd;
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      req_in    = req_ff;
      strobe_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + PW'(1);
            if (clr_ff == LAST_ENTRY) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= '0;
         free_cnt_ff  <= CW'(POOL_DEPTH);
         run_entry_ff <= '0;
         run_level_ff <= '0;
         run_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         free_cnt_ff  <= free_cnt_in;
         run_entry_ff <= run_entry_in;
         run_level_ff <= run_level_in;
         run_valid_ff <= run_valid_in;
         strobe_ff    <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== src/spts_checker.sv =====
module spts_checker import spts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // An accepted request keeps the block busy while it executes
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after a request was accepted");

   // Every accepted request is answered by a response strobe
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("response strobe missing two cycles after accept");

   // Response strobes never come in consecutive cycles
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobes in consecutive cycles");

   // A dispatched task is only reported with ok status
   a_run_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.run_valid) |-> (rsp_item.status == ST_OK))
      else $error("run_valid set with a failing status");

endmodule

bind strict_priority_task_scheduler spts_checker u_spts_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
